// ===== src/ultrasonic_echo_ranger_core_defines.svh =====
// assertion macros shared by the ranger checker
`ifndef ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH

// same-cycle implication under a disable condition
`define UER_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("uer check failed: same-cycle rule");

// next-cycle implication under a disable condition
`define UER_ASSERT_NXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("uer check failed: next-cycle rule");

`endif

// ===== src/uer_pkg.sv =====
// types, register codes and constants of the ultrasonic echo ranger
package uer_pkg;

  localparam int CNT_W      = 32;
  localparam int SINCE_W    = 20;
  localparam int WIDTH_W    = 16;
  localparam int TRIG_W     = 10;
  localparam int DIST_W     = 14;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_CNT_W  = 32;

  // width*343/2000 as one multiply by a scaled reciprocal
  localparam int               DIST_SHIFT = 30;
  localparam int               DIST_MUL_W = 28;
  localparam logic [DIST_MUL_W-1:0] DIST_MUL = 28'd184146723;
  localparam int               PROD_W     = WIDTH_W + DIST_MUL_W;

  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  // register reset values
  localparam logic [SINCE_W-1:0] RST_REPEAT   = 20'd60000;
  localparam logic [SINCE_W-1:0] RST_TIMEOUT  = 20'd35000;
  localparam logic [WIDTH_W-1:0] RST_MIN_ECHO = 16'd117;
  localparam logic [WIDTH_W-1:0] RST_MAX_ECHO = 16'd23323;
  localparam logic [TRIG_W-1:0]  RST_TRIG_W   = 10'd10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ECHO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_W   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_WAIT_RISE = 3'd1,
    ST_WAIT_FALL = 3'd2,
    ST_FAIL      = 3'd3,
    ST_VALID     = 3'd4
  } uer_status_t;

  typedef struct packed {
    logic echo_level;
    logic take_result;
  } uer_in_t;

  typedef struct packed {
    logic                 trigger_out;
    uer_status_t          status;
    logic                 result_ready;
    logic                 result_taken;
    logic [WIDTH_W-1:0]   echo_width_us;
    logic [DIST_W-1:0]    dist_mm;
    logic [OUT_CNT_W-1:0] trigger_total;
    logic [OUT_CNT_W-1:0] rise_total;
    logic [OUT_CNT_W-1:0] fall_total;
  } uer_out_t;

  typedef struct packed {
    logic [SINCE_W-1:0] repeat_interval_us;
    logic [SINCE_W-1:0] timeout_us;
    logic [WIDTH_W-1:0] min_echo_us;
    logic [WIDTH_W-1:0] max_echo_us;
    logic [TRIG_W-1:0]  trigger_width_us;
  } uer_cfg_t;

  typedef struct packed {
    logic               busy;
    logic               awaiting_rise;
    logic               echo_prev;
    logic               ready_flag;
    uer_status_t        status;
    logic [SINCE_W-1:0] since_trigger;
    logic [WIDTH_W-1:0] pulse_width;
    logic [TRIG_W-1:0]  trigger_left;
    logic [WIDTH_W-1:0] held_width;
    logic [DIST_W-1:0]  held_distance;
    logic [CNT_W-1:0]   trigger_cnt;
    logic [CNT_W-1:0]   rise_cnt;
    logic [CNT_W-1:0]   fall_cnt;
  } uer_state_t;

endpackage

// ===== src/ultrasonic_echo_ranger_core.sv =====
// Ultrasonic echo ranger: one input beat per microsecond tick gives one result beat. The
// block takes a beat in every clock cycle while the result side keeps up, and each result
// appears in the output register in the cycle after its tick is accepted. The rate is set
// by the single combinational pass from the state register to the result register, whose
// longest path is the 16 by 28 bit multiply that turns the echo width into millimetres.
// The output register lets a new tick enter in the same cycle that the waiting result
// leaves. Registers must be written via the cfg port only while no tick is in flight; the
// block does not enforce it. Unused indexes ignore writes. No clearing pass follows reset.
module ultrasonic_echo_ranger_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  uer_pkg::uer_in_t                       in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output uer_pkg::uer_out_t                      out_data,
  input  logic                                   cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import uer_pkg::*;

  uer_cfg_t   cfg_r;
  uer_state_t state_r;
  uer_state_t state_nxt;
  uer_out_t   res_nxt;
  uer_out_t   out_data_r;
  logic       out_valid_r;
  logic       in_fire;

  // a tick enters whenever the output register is empty or being drained
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_interval_us <= RST_REPEAT;
      cfg_r.timeout_us         <= RST_TIMEOUT;
      cfg_r.min_echo_us        <= RST_MIN_ECHO;
      cfg_r.max_echo_us        <= RST_MAX_ECHO;
      cfg_r.trigger_width_us   <= RST_TRIG_W;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REPEAT:   cfg_r.repeat_interval_us <= cfg_wdata;
        REG_TIMEOUT:  cfg_r.timeout_us         <= cfg_wdata;
        REG_MIN_ECHO: cfg_r.min_echo_us        <= cfg_wdata[WIDTH_W-1:0];
        REG_MAX_ECHO: cfg_r.max_echo_us        <= cfg_wdata[WIDTH_W-1:0];
        REG_TRIG_W:   cfg_r.trigger_width_us   <= cfg_wdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // tick logic
  uer_step u_step (
    .cfg     (cfg_r),
    .cur     (state_r),
    .in_beat (in_data),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  // measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.busy          <= 1'b0;
      state_r.awaiting_rise <= 1'b0;
      state_r.echo_prev     <= 1'b0;
      state_r.ready_flag    <= 1'b0;
      state_r.status        <= ST_IDLE;
      state_r.since_trigger <= RST_REPEAT;
      state_r.pulse_width   <= '0;
      state_r.trigger_left  <= '0;
      state_r.held_width    <= '0;
      state_r.held_distance <= '0;
      state_r.trigger_cnt   <= '0;
      state_r.rise_cnt      <= '0;
      state_r.fall_cnt      <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

// ===== src/uer_step.sv =====
// next-state and result logic for one microsecond tick
module uer_step (
  input  uer_pkg::uer_cfg_t   cfg,
  input  uer_pkg::uer_state_t cur,
  input  uer_pkg::uer_in_t    in_beat,
  output uer_pkg::uer_state_t nxt,
  output uer_pkg::uer_out_t   res
);
  import uer_pkg::*;

  uer_state_t          s;
  logic                taken;
  logic                rise_edge;
  logic                fall_edge;
  logic                in_range;
  logic [PROD_W-1:0]   prod;
  logic [SINCE_W-1:0]  since_inc;
  logic [WIDTH_W-1:0]  width_inc;

  // counters advanced before edges are looked at
  always_comb begin
    since_inc = (cur.since_trigger < SINCE_MAX) ? cur.since_trigger + 1'b1
                                                 : cur.since_trigger;
    width_inc = (cur.busy && !cur.awaiting_rise && cur.pulse_width < WIDTH_MAX)
                ? cur.pulse_width + 1'b1 : cur.pulse_width;
  end

  // distance from the width that a falling edge would close
  assign prod     = PROD_W'(width_inc) * PROD_W'(DIST_MUL);
  assign in_range = (width_inc >= cfg.min_echo_us) && (width_inc <= cfg.max_echo_us);

  assign rise_edge = in_beat.echo_level && !cur.echo_prev;
  assign fall_edge = !in_beat.echo_level && cur.echo_prev;
  assign taken     = in_beat.take_result && cur.ready_flag;

  always_comb begin
    s = cur;
    s.since_trigger = since_inc;
    s.pulse_width   = width_inc;

    // take request
    if (taken) begin
      s.ready_flag = 1'b0;
      s.status     = ST_IDLE;
    end

    // echo edges
    if (rise_edge) begin
      if (cur.busy && cur.awaiting_rise) begin
        s.rise_cnt      = cur.rise_cnt + 1'b1;
        s.awaiting_rise = 1'b0;
        s.pulse_width   = '0;
        s.status        = ST_WAIT_FALL;
      end
    end else if (fall_edge) begin
      if (cur.busy && !cur.awaiting_rise) begin
        s.fall_cnt = cur.fall_cnt + 1'b1;
        s.busy     = 1'b0;
        if (in_range) begin
          s.held_width    = width_inc;
          s.held_distance = prod[DIST_SHIFT +: DIST_W];
          s.ready_flag    = 1'b1;
          s.status        = ST_VALID;
        end else begin
          s.status = ST_FAIL;
        end
      end
    end
    s.echo_prev = in_beat.echo_level;

    // timeout after edges
    if (s.busy && since_inc >= cfg.timeout_us) begin
      s.busy          = 1'b0;
      s.awaiting_rise = 1'b0;
      s.status        = ST_FAIL;
    end

    // trigger after timeout
    if (!s.busy && since_inc >= cfg.repeat_interval_us) begin
      s.busy          = 1'b1;
      s.awaiting_rise = 1'b1;
      s.status        = ST_WAIT_RISE;
      s.since_trigger = '0;
      s.trigger_cnt   = cur.trigger_cnt + 1'b1;
      s.trigger_left  = cfg.trigger_width_us;
    end

    // result fields before the pulse counter steps
    res.trigger_out   = (s.trigger_left != '0);
    res.status        = s.status;
    res.result_ready  = s.ready_flag;
    res.result_taken  = taken;
    res.echo_width_us = s.held_width;
    res.dist_mm       = s.held_distance;
    res.trigger_total = OUT_CNT_W'(s.trigger_cnt);
    res.rise_total    = OUT_CNT_W'(s.rise_cnt);
    res.fall_total    = OUT_CNT_W'(s.fall_cnt);

    if (s.trigger_left != '0) begin
      s.trigger_left = s.trigger_left - 1'b1;
    end
    nxt = s;
  end

endmodule

// ===== src/uer_checker.sv =====
// port-level checks for the ranger core and their bind
`include "ultrasonic_echo_ranger_core_defines.svh"

module uer_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input uer_pkg::uer_out_t out_data
);
  import uer_pkg::*;

  // a stalled result beat holds
  `UER_ASSERT_NXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // an empty output register never blocks the input
  `UER_ASSERT_IMP(a_empty_takes, clk, !rst_n, !out_valid, in_ready)

  // a valid status always comes with a waiting measurement
  `UER_ASSERT_IMP(a_valid_ready, clk, !rst_n, out_valid && out_data.status == ST_VALID, out_data.result_ready)

  // reset empties the result side
  `UER_ASSERT_NXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid)

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (.*);

// ===== verif/ultrasonic_echo_ranger_core_test.sv =====
// self-checking testbench for the ultrasonic echo ranger core
module ultrasonic_echo_ranger_core_test;
  import uer_pkg::*;

  localparam int LONG_HOLD    = 50;
  localparam int LONG_ECHO    = 60;
  localparam int MAX_REPORTS  = 20;
  localparam int LIMIT_CYCLES = 3000000;
  localparam logic [31:0] SOUND_NUM = 32'd343;
  localparam logic [31:0] SOUND_DEN = 32'd2000;
  // index past the last register, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  uer_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  uer_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor copy of the ranger state and registers
  uer_state_t ranger_st;
  uer_cfg_t   ranger_cfg;
  uer_out_t   expected_readings[$];

  int mismatches  = 0;
  int ticks_sent  = 0;
  bit gaps_on     = 1'b1;
  bit stalls_on   = 1'b1;
  int holds_asked = 0;
  int holds_given = 0;

  ultrasonic_echo_ranger_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one microsecond tick of the ranger, returns the reading it produces
  function automatic uer_out_t predict_reading(input uer_in_t beat);
    uer_out_t r;
    r.result_taken = 1'b0;
    // a take consumes the ready measurement and drops status to idle
    if (beat.take_result && ranger_st.ready_flag) begin
      ranger_st.ready_flag = 1'b0;
      ranger_st.status     = ST_IDLE;
      r.result_taken       = 1'b1;
    end
    // elapsed time and echo width, both saturating
    if (ranger_st.since_trigger != SINCE_MAX)
      ranger_st.since_trigger = ranger_st.since_trigger + 1'b1;
    if (ranger_st.busy && !ranger_st.awaiting_rise && ranger_st.pulse_width != WIDTH_MAX)
      ranger_st.pulse_width = ranger_st.pulse_width + 1'b1;
    // edges count only in the phase of the measurement that expects them
    if (beat.echo_level && !ranger_st.echo_prev) begin
      if (ranger_st.busy && ranger_st.awaiting_rise) begin
        ranger_st.rise_cnt      = ranger_st.rise_cnt + 1'b1;
        ranger_st.awaiting_rise = 1'b0;
        ranger_st.pulse_width   = '0;
        ranger_st.status        = ST_WAIT_FALL;
      end
    end else if (!beat.echo_level && ranger_st.echo_prev) begin
      if (ranger_st.busy && !ranger_st.awaiting_rise) begin
        ranger_st.fall_cnt = ranger_st.fall_cnt + 1'b1;
        ranger_st.busy     = 1'b0;
        if (ranger_st.pulse_width >= ranger_cfg.min_echo_us &&
            ranger_st.pulse_width <= ranger_cfg.max_echo_us) begin
          ranger_st.held_width    = ranger_st.pulse_width;
          ranger_st.held_distance =
            DIST_W'((ranger_st.pulse_width * SOUND_NUM) / SOUND_DEN);
          ranger_st.ready_flag    = 1'b1;
          ranger_st.status        = ST_VALID;
        end else begin
          ranger_st.status = ST_FAIL;
        end
      end
    end
    ranger_st.echo_prev = beat.echo_level;
    // timeout of an unfinished measurement
    if (ranger_st.busy && ranger_st.since_trigger >= ranger_cfg.timeout_us) begin
      ranger_st.busy          = 1'b0;
      ranger_st.awaiting_rise = 1'b0;
      ranger_st.status        = ST_FAIL;
    end
    // new trigger once the repeat interval has passed
    if (!ranger_st.busy && ranger_st.since_trigger >= ranger_cfg.repeat_interval_us) begin
      ranger_st.busy          = 1'b1;
      ranger_st.awaiting_rise = 1'b1;
      ranger_st.status        = ST_WAIT_RISE;
      ranger_st.since_trigger = '0;
      ranger_st.trigger_cnt   = ranger_st.trigger_cnt + 1'b1;
      ranger_st.trigger_left  = ranger_cfg.trigger_width_us;
    end
    r.trigger_out = ranger_st.trigger_left != '0;
    if (r.trigger_out)
      ranger_st.trigger_left = ranger_st.trigger_left - 1'b1;
    r.status        = ranger_st.status;
    r.result_ready  = ranger_st.ready_flag;
    r.echo_width_us = ranger_st.held_width;
    r.dist_mm       = ranger_st.held_distance;
    r.trigger_total = ranger_st.trigger_cnt;
    r.rise_total    = ranger_st.rise_cnt;
    r.fall_total    = ranger_st.fall_cnt;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
  endtask

  // register writes, input beats and result beats as seen at each edge
  always @(posedge clk) begin : scoreboard
    uer_out_t want;
    if (!rst_n) begin
      ranger_st = '0;
      ranger_st.since_trigger = RST_REPEAT;
      ranger_cfg = '{RST_REPEAT, RST_TIMEOUT, RST_MIN_ECHO, RST_MAX_ECHO, RST_TRIG_W};
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REPEAT:   ranger_cfg.repeat_interval_us = cfg_wdata;
          REG_TIMEOUT:  ranger_cfg.timeout_us         = cfg_wdata;
          REG_MIN_ECHO: ranger_cfg.min_echo_us        = cfg_wdata[WIDTH_W-1:0];
          REG_MAX_ECHO: ranger_cfg.max_echo_us        = cfg_wdata[WIDTH_W-1:0];
          REG_TRIG_W:   ranger_cfg.trigger_width_us   = cfg_wdata[TRIG_W-1:0];
          default: ;
        endcase
      end
      // result first, so a beat leaving and one entering in the same edge stay in order
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          note_mismatch("result beat with nothing expected", 32'd0, 32'd0);
        end else begin
          want = expected_readings.pop_front();
          if (out_data.trigger_out !== want.trigger_out)
            note_mismatch("trigger_out", 32'(out_data.trigger_out), 32'(want.trigger_out));
          if (out_data.status !== want.status)
            note_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.result_ready !== want.result_ready)
            note_mismatch("result_ready", 32'(out_data.result_ready),
                          32'(want.result_ready));
          if (out_data.result_taken !== want.result_taken)
            note_mismatch("result_taken", 32'(out_data.result_taken),
                          32'(want.result_taken));
          if (out_data.echo_width_us !== want.echo_width_us)
            note_mismatch("echo_width_us", 32'(out_data.echo_width_us),
                          32'(want.echo_width_us));
          if (out_data.dist_mm !== want.dist_mm)
            note_mismatch("dist_mm", 32'(out_data.dist_mm), 32'(want.dist_mm));
          if (out_data.trigger_total !== want.trigger_total)
            note_mismatch("trigger_total", out_data.trigger_total, want.trigger_total);
          if (out_data.rise_total !== want.rise_total)
            note_mismatch("rise_total", out_data.rise_total, want.rise_total);
          if (out_data.fall_total !== want.fall_total)
            note_mismatch("fall_total", out_data.fall_total, want.fall_total);
        end
      end
      if (in_valid && in_ready)
        expected_readings.push_back(predict_reading(in_data));
    end
  end

  // result side: random stall bursts, plus one long hold when asked
  initial begin : result_sink
    forever begin
      if (holds_given != holds_asked) begin
        holds_given++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one tick beat, with an occasional idle burst ahead of it
  task automatic send_tick(input bit echo, input bit take);
    uer_in_t beat;
    beat.echo_level  = echo;
    beat.take_result = take;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // low for lead ticks, high for high ticks, low for tail ticks
  task automatic echo_pulse(input int lead, input int high, input int tail, input bit take_first);
    for (int i = 0; i < lead + high + tail; i++)
      send_tick(i >= lead && i < lead + high, take_first && i == 0);
  endtask

  task automatic random_pulse();
    echo_pulse($urandom_range(0, 12), $urandom_range(1, 45), $urandom_range(0, 6),
               $urandom_range(0, 3) == 0);
  endtask

  // stop offering and wait until every expected reading has come back
  task automatic wait_readings_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic load_regs(input int rep, input int tmo, input int lo, input int hi,
                           input int tw);
    put_reg(REG_REPEAT, rep);
    put_reg(REG_TIMEOUT, tmo);
    put_reg(REG_MIN_ECHO, lo);
    put_reg(REG_MAX_ECHO, hi);
    put_reg(REG_TRIG_W, tw);
    cfg_we <= 1'b0;
  endtask

  // reset values: immediate first trigger, a short echo that gets rejected
  task automatic test_reset_defaults();
    repeat (3) send_tick(1'b0, 1'b1);
    repeat (4) send_tick(1'b1, 1'b0);
    repeat (6) send_tick(1'b0, 1'b0);
  endtask

  // width limits, take during a running measurement, timeouts in both phases
  task automatic test_echo_window();
    wait_readings_drained();
    load_regs(1, 40, 3, 6, 2);
    echo_pulse(2, 2, 1, 1'b0);
    echo_pulse(2, 3, 1, 1'b0);
    echo_pulse(2, 6, 1, 1'b1);
    echo_pulse(2, 7, 1, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (45) send_tick(1'b0, 1'b0);
    echo_pulse(1, 45, 1, 1'b0);
  endtask

  // zero and full-scale registers, empty window, dropped write to an unused index
  task automatic test_register_extremes();
    wait_readings_drained();
    load_regs(0, 0, 0, 65535, 0);
    echo_pulse(1, 2, 1, 1'b0);
    wait_readings_drained();
    // back-to-back triggers restart a running pulse
    load_regs(0, 0, 0, 65535, 5);
    repeat (4) send_tick(1'b0, 1'b0);
    wait_readings_drained();
    put_reg(REG_UNUSED, -1);
    load_regs(1, 1000000, 100, 50, 1000);
    echo_pulse(1, 3, 2, 1'b0);
    wait_readings_drained();
    load_regs(1000000, 1, 0, 0, 1);
    echo_pulse(1, 1, 1, 1'b0);
  endtask

  // long echo under a wide-open window, gives a wide distance
  task automatic test_long_echo();
    wait_readings_drained();
    load_regs(1, 1000000, 0, 65535, 10);
    repeat (2) send_tick(1'b0, 1'b0);
    repeat (LONG_ECHO) send_tick(1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1);
  endtask

  // result side held off while beats keep coming, so the input stalls
  task automatic test_output_stall();
    holds_asked++;
    repeat (4) random_pulse();
  endtask

  // random settings per phase, pulse trains with noise bursts between them
  task automatic test_random_traffic(input int phases, input int ticks);
    int start;
    int lo;
    for (int p = 0; p < phases; p++) begin
      wait_readings_drained();
      lo = $urandom_range(0, 10);
      load_regs($urandom_range(0, 40), $urandom_range(0, 80), lo,
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, lo) : $urandom_range(lo, 40),
                $urandom_range(0, 12));
      start = ticks_sent;
      while (ticks_sent - start < ticks) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 6))
            send_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
        else
          random_pulse();
      end
    end
  endtask

  initial begin : test_sequence
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_REPEAT;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_echo_window();
    test_register_extremes();
    test_long_echo();
    test_random_traffic(3, 40);
    test_output_stall();
    test_random_traffic(2, 40);
    // closing stretch runs without idling on either side
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_traffic(1, 40);
    wait_readings_drained();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #(20 * LIMIT_CYCLES);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
